>>> design/top_k_sorted_insert_table_macros.svh
// assertion macros used by the bound checker file
`ifndef TOP_K_SORTED_INSERT_TABLE_MACROS_SVH
`define TOP_K_SORTED_INSERT_TABLE_MACROS_SVH

// same-cycle implication, off during reset
`define TKST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkst assertion failed");

// next-cycle implication, off during reset
`define TKST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkst assertion failed");

`endif

>>> design/tkst_pkg.sv
package tkst_pkg;

  // fixed field widths
  localparam int SCORE_W = 32;
  localparam int TAG_W   = 32;
  localparam int INDEX_W = 4;
  localparam int RANK_W  = 4;
  localparam int COUNT_W = 5;

  // operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [RANK_W-1:0]  rank;
    logic [COUNT_W-1:0] entry_count;
    logic               read_valid;
    logic [SCORE_W-1:0] read_score;
    logic [TAG_W-1:0]   read_tag;
  } out_item_t;

endpackage

>>> design/tkst_stream_if.sv
interface tkst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/top_k_sorted_insert_table.sv
// read: the entry comes through the registered read port; S_RD registers the result once the output is free
// insert: S_CMP shifts each lower-scored entry down one place, then S_PUT or the
//   stopping compare goes to S_OUT; a full table first checks its last entry in S_CHK
// a new transaction is taken only in S_IDLE, after the last result is registered and any
//   result stall has cleared; the single read port of the entry memory sets the pace
// reset clears the entry count and control state; memory contents are not cleared
module top_k_sorted_insert_table #(
  parameter int MAX_ENTRIES = 16,
  parameter int TAG_CHARS   = 4
) (
  input logic          clk_i,
  input logic          rst_ni,
  tkst_stream_if.sink   in_i,
  tkst_stream_if.source out_o
);
  import tkst_pkg::*;

  localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW      = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W   = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int STORE_W = (TAG_CHARS >= 4) ? TAG_W : 8 * TAG_CHARS;
  localparam int ENT_W   = SCORE_W + STORE_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [STORE_W-1:0] tag_q, tag_d;
  logic               rd_ok_q, rd_ok_d;
  logic               acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic [ENT_W-1:0]   mem_q [MAX_ENTRIES];
  logic [ENT_W-1:0]   rd_data_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [ENT_W-1:0]   wr_data;

  logic [SCORE_W-1:0] rd_score;
  logic [STORE_W-1:0] rd_tag;
  logic               out_free;
  in_item_t           in_item;

  assign in_item  = in_i.data;
  assign rd_score = rd_data_q[ENT_W-1 -: SCORE_W];
  assign rd_tag   = rd_data_q[STORE_W-1:0];
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // insertion walk: read the entry above, move it down or drop the new pair in
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    score_d     = score_q;
    tag_d       = tag_q;
    rd_ok_d     = rd_ok_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = {score_q, tag_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          score_d = in_item.score;
          tag_d   = STORE_W'(in_item.tag);
          if (in_item.mode == MODE_READ) begin
            rd_ok_d = CMP_W'(in_item.index) < CMP_W'(count_q);
            rd_en   = 1'b1;
            rd_addr = AW'(in_item.index);
            state_d = S_RD;
          end else if (count_q == CW'(MAX_ENTRIES)) begin
            // full table: fetch the last entry for the reject check
            rd_en   = 1'b1;
            rd_addr = AW'(MAX_ENTRIES - 1);
            pos_d   = AW'(MAX_ENTRIES - 1);
            state_d = S_CHK;
          end else begin
            count_d = count_q + CW'(1);
            pos_d   = AW'(count_q);
            if (count_q == '0) begin
              state_d = S_PUT;
            end else begin
              rd_en   = 1'b1;
              rd_addr = AW'(count_q - CW'(1));
              state_d = S_CMP;
            end
          end
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.accepted    = 1'b0;
          out_data_d.rank        = '0;
          out_data_d.entry_count = COUNT_W'(count_q);
          out_data_d.read_valid  = rd_ok_q;
          out_data_d.read_score  = rd_ok_q ? rd_score : '0;
          out_data_d.read_tag    = rd_ok_q ? TAG_W'(rd_tag) : '0;
          state_d                = S_IDLE;
        end
      end
      S_CHK: begin
        if (score_q <= rd_score) begin
          acc_d   = 1'b0;
          state_d = S_OUT;
        end else if (pos_q == '0) begin
          state_d = S_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_q - AW'(1);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (score_q > rd_score) begin
          // shift the entry above down one place
          wr_data = rd_data_q;
          pos_d   = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_q - AW'(2);
          end
        end else begin
          acc_d   = 1'b1;
          state_d = S_OUT;
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        pos_d   = '0;
        acc_d   = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.accepted    = acc_q;
          out_data_d.rank        = acc_q ? RANK_W'(pos_q) : '0;
          out_data_d.entry_count = COUNT_W'(count_q);
          out_data_d.read_valid  = 1'b0;
          out_data_d.read_score  = '0;
          out_data_d.read_tag    = '0;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    score_q    <= score_d;
    tag_q      <= tag_d;
    rd_ok_q    <= rd_ok_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

endmodule

>>> design/tkst_checker.sv
`include "top_k_sorted_insert_table_macros.svh"

module tkst_checker #(
  parameter int MAX_ENTRIES = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input tkst_pkg::out_item_t out_data_i
);
  import tkst_pkg::*;

  // stalled result holds
  `TKST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  // count never passes capacity
  `TKST_ASSERT_IMPL(a_count_cap, clk_i, rst_ni, out_valid_i, (MAX_ENTRIES > 31) || (out_data_i.entry_count <= COUNT_W'(MAX_ENTRIES)))

  // a result is an insert or a read, never both
  `TKST_ASSERT_IMPL(a_kind_excl, clk_i, rst_ni, out_valid_i, !(out_data_i.accepted && out_data_i.read_valid))

  // rank is zero unless the insert landed
  `TKST_ASSERT_IMPL(a_rank_zero, clk_i, rst_ni, out_valid_i && !out_data_i.accepted, out_data_i.rank == '0)

  // read fields are zero unless the read hit
  `TKST_ASSERT_IMPL(a_read_zero, clk_i, rst_ni, out_valid_i && !out_data_i.read_valid, (out_data_i.read_score == '0) && (out_data_i.read_tag == '0))

endmodule

bind top_k_sorted_insert_table tkst_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_tkst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

>>> bench/top_k_sorted_insert_table_checker.sv
module top_k_sorted_insert_table_checker #(
  parameter int MAX_ENTRIES = 16,
  parameter int TAG_CHARS   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  tkst_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  tkst_pkg::out_item_t out_data_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tkst_pkg::*;

  // bytes of the tag that the table keeps
  localparam logic [63:0] TAG_KEEP = (TAG_CHARS >= 4) ? 64'hFFFF_FFFF
                                                      : (64'd1 << (8 * TAG_CHARS)) - 64'd1;

  // mirror of the ranked table
  logic [SCORE_W-1:0] ranked_scores [MAX_ENTRIES];
  logic [TAG_W-1:0]   ranked_tags   [MAX_ENTRIES];
  int unsigned        filled;

  // outcomes of accepted transactions, oldest first
  out_item_t          ranked_outcomes [$];

  // insert into or read from the mirrored table, giving the outcome
  function automatic out_item_t place_or_read(input in_item_t item);
    out_item_t          res;
    logic [TAG_W-1:0]   kept_tag;
    int                 pos;
    bit                 take;
    res      = '0;
    kept_tag = item.tag & TAG_KEEP[TAG_W-1:0];
    if (item.mode == MODE_INSERT) begin
      take = 1'b1;
      if (filled >= MAX_ENTRIES) begin
        filled = MAX_ENTRIES;
        // a full table only takes a score strictly above its last entry
        if (item.score <= ranked_scores[MAX_ENTRIES-1]) take = 1'b0;
      end else begin
        filled++;
      end
      if (take) begin
        pos = int'(filled) - 1;
        // equal scores stay above the new entry
        while (pos >= 1 && item.score > ranked_scores[pos-1]) begin
          ranked_scores[pos] = ranked_scores[pos-1];
          ranked_tags[pos]   = ranked_tags[pos-1];
          pos--;
        end
        ranked_scores[pos] = item.score;
        ranked_tags[pos]   = kept_tag;
        res.accepted       = 1'b1;
        res.rank           = RANK_W'(pos);
      end
    end else if (item.index < filled && item.index < MAX_ENTRIES) begin
      res.read_valid = 1'b1;
      res.read_score = ranked_scores[item.index];
      res.read_tag   = ranked_tags[item.index];
    end
    res.entry_count = COUNT_W'(filled);
    return res;
  endfunction

  // one field against its expected value
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  // compare results, then predict from new input transactions
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      filled = 0;
      ranked_outcomes.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (ranked_outcomes.size() == 0) begin
          $display("%0t: result with nothing expected, got %0h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = ranked_outcomes.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(out_data_i.accepted));
          check_field("rank", 32'(want.rank), 32'(out_data_i.rank));
          check_field("entry_count", 32'(want.entry_count), 32'(out_data_i.entry_count));
          check_field("read_valid", 32'(want.read_valid), 32'(out_data_i.read_valid));
          check_field("read_score", want.read_score, out_data_i.read_score);
          check_field("read_tag", want.read_tag, out_data_i.read_tag);
        end
      end
      if (in_valid_i && in_ready_i) ranked_outcomes.push_back(place_or_read(in_data_i));
      pending_o = ranked_outcomes.size();
    end
  end

endmodule

>>> bench/tb_top_k_sorted_insert_table.sv
module tb_top_k_sorted_insert_table;
  timeunit 1ns;
  timeprecision 1ps;
  import tkst_pkg::*;

  localparam int MAX_ENTRIES   = 16;
  localparam int TAG_CHARS     = 4;
  localparam int RANDOM_ITEMS  = 1225;
  localparam int STALL_LIMIT   = 2000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          src_burst;
  bit          snk_burst;

  tkst_stream_if #(.payload_t(in_item_t))  in_ch ();
  tkst_stream_if #(.payload_t(out_item_t)) out_ch ();

  top_k_sorted_insert_table #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .TAG_CHARS  (TAG_CHARS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  top_k_sorted_insert_table_checker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .TAG_CHARS  (TAG_CHARS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // insert transaction, unused index bits random
  function automatic in_item_t insert_item(input logic [SCORE_W-1:0] score,
                                           input logic [TAG_W-1:0] tag);
    in_item_t item;
    item.mode  = MODE_INSERT;
    item.score = score;
    item.tag   = tag;
    item.index = INDEX_W'($urandom);
    return item;
  endfunction

  // read transaction, unused score and tag random
  function automatic in_item_t read_item(input logic [INDEX_W-1:0] index);
    in_item_t item;
    item.mode  = MODE_READ;
    item.score = $urandom;
    item.tag   = $urandom;
    item.index = index;
    return item;
  endfunction

  // send one transaction after a random gap; entered and left at a falling edge
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.data  <= item;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk_i);
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int unsigned base;
    logic [SCORE_W-1:0] score;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    src_burst    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reads on an empty table, extremes, ties at top and bottom
    send_item(read_item(4'd0));
    send_item(read_item(4'd15));
    send_item(insert_item(32'h0000_0000, 32'hFFFF_FFFF));
    send_item(insert_item(32'hFFFF_FFFF, 32'h0000_0000));
    send_item(insert_item(32'h0000_0000, 32'h0000_0001));
    send_item(insert_item(32'hFFFF_FFFF, 32'h0000_0002));
    send_item(insert_item(32'd5, 32'h0000_0003));
    send_item(read_item(4'd0));
    send_item(read_item(4'd4));
    send_item(read_item(4'd5));
    // fill the table in mixed order
    for (int i = 0; i < 11; i++) send_item(insert_item(32'(10 + (i * 7) % 11), $urandom));
    // full table: equal to last rejected, above last accepted
    send_item(insert_item(32'd0, $urandom));
    send_item(insert_item(32'd1, $urandom));
    send_item(read_item(4'd15));
    send_item(insert_item(32'd0, $urandom));

    // random part: a rising score band keeps inserts landing in the table
    base = 32'h100;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 0) drain_results();
      if (n % 150 == 0) src_burst = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 3) begin
        send_item(read_item(INDEX_W'($urandom)));
      end else begin
        base += $urandom_range(0, 3);
        if ($urandom_range(0, 15) == 0) score = $urandom_range(0, base);
        else score = base + $urandom_range(0, 48);
        send_item(insert_item(score, $urandom));
      end
    end

    // let outstanding results arrive, then a short quiet period
    drain_results();
    repeat (MAX_ENTRIES + 8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("top_k_sorted_insert_table: match");
    end else begin
      $display("top_k_sorted_insert_table: mismatch");
    end
    $finish;
  end

  // result side: random stall after each transaction, with stall-free stretches
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    out_ch.ready = 1'b0;
    taken        = 0;
    snk_burst    = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    out_ch.ready <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      taken++;
      if (taken % 130 == 0) snk_burst = ($urandom_range(0, 2) == 0);
      gap = snk_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("top_k_sorted_insert_table: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
